FILE: design/gctf_pkg.sv
// ----------------------------------------------------------------------------
// gctf_pkg
// Types, register codes and helpers shared by the glyph cell fit block.
// ----------------------------------------------------------------------------
package gctf_pkg;

	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;
	localparam int PIXEL_W      = 32;
	localparam int COL_W        = 6;
	localparam int WIDTH_W      = 7;
	localparam int RGB_W        = 24;
	localparam int COL_LIMIT    = 64;

	localparam logic [RGB_W-1:0]   PAPER_RESET = 24'hFF0000;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd8;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_PAPER = 2'd0,
		REG_ALPHA = 2'd1,
		REG_WIDTH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [RGB_W-1:0]   paper;
		logic [RGB_W-1:0]   paper2;
		logic               use_alpha;
		logic [WIDTH_W-1:0] cell_width;
	} cfg_t;

	// floor(c*2/3) or floor(c*4/3), clamped to 255; x/3 as x*683 >> 11
	function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic shrink);
		logic [9:0]  v;
		logic [20:0] prod;
		logic [9:0]  q;
		v    = shrink ? {1'b0, c, 1'b0} : {c, 2'b00};
		prod = 21'(v) * 21'd683;
		q    = prod[20:11];
		return (q > 10'd255) ? 8'd255 : q[7:0];
	endfunction

	function automatic logic [RGB_W-1:0] second_paper(input logic [RGB_W-1:0] p);
		logic shrink;
		shrink = p[23] | p[15] | p[7];
		return {scale_channel(p[23:16], shrink), scale_channel(p[15:8], shrink),
			scale_channel(p[7:0], shrink)};
	endfunction

endpackage

FILE: design/gctf_if.sv
// ----------------------------------------------------------------------------
// gctf_pix_if / gctf_fit_if
// Valid/ready channels for pixel words and fit result words.
// ----------------------------------------------------------------------------
interface gctf_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel;
	logic [5:0]  column;
	logic        cell_end;
	logic        no_fit;

	modport source (output valid, output pixel, output column, output cell_end,
		output no_fit, input ready);
	modport sink (input valid, input pixel, input column, input cell_end,
		input no_fit, output ready);
endinterface

interface gctf_fit_if;
	logic       valid;
	logic       ready;
	logic [5:0] left_offset;
	logic [6:0] fit_width;
	logic       found;

	modport source (output valid, output left_offset, output fit_width, output found,
		input ready);
	modport sink (input valid, input left_offset, input fit_width, input found,
		output ready);
endinterface

FILE: design/gctf_cfg_regs.sv
// ----------------------------------------------------------------------------
// gctf_cfg_regs
// APB register file; derives the second paper color on each paper write.
// ----------------------------------------------------------------------------
module gctf_cfg_regs
	import gctf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [RGB_W-1:0]   paper_q;
	logic [RGB_W-1:0]   paper2_q;
	logic               use_alpha_q;
	logic [WIDTH_W-1:0] cell_width_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paper_q      <= PAPER_RESET;
			paper2_q     <= second_paper(PAPER_RESET);
			use_alpha_q  <= 1'b1;
			cell_width_q <= WIDTH_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_PAPER: begin
					paper_q  <= pwdata[RGB_W-1:0];
					paper2_q <= second_paper(pwdata[RGB_W-1:0]);
				end
				REG_ALPHA: use_alpha_q  <= pwdata[0];
				REG_WIDTH: cell_width_q <= pwdata[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PAPER: prdata = {{(DATA_W-RGB_W){1'b0}}, paper_q};
			REG_ALPHA: prdata = {{(DATA_W-1){1'b0}}, use_alpha_q};
			REG_WIDTH: prdata = {{(DATA_W-WIDTH_W){1'b0}}, cell_width_q};
			default:   prdata = '0;
		endcase
	end

	assign cfg = '{paper: paper_q, paper2: paper2_q, use_alpha: use_alpha_q,
		cell_width: cell_width_q};

	// derived color always tracks the stored paper
	a_paper2: assert property (@(posedge clk) disable iff (!arst_n)
		paper2_q == second_paper(paper_q))
		else $error("second paper out of step with paper");

endmodule

FILE: design/glyph_cell_tight_fit.sv
// ----------------------------------------------------------------------------
// glyph_cell_tight_fit
// Horizontal ink extent of one glyph cell from a stream of ARGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   pix carries one pixel word per handshake with its column and a cell_end
//   mark on the last pixel of the cell; no_fit is looked at on that pixel only.
//   fit carries one result word per cell: left_offset, fit_width and found.
//   Registers sit on the APB port: paper color at 0x0, alpha mode at 0x4,
//   cell width at 0x8; change them only while the block is idle.
//   Throughput is one pixel per cycle unless a cell_end word waits for the
//   result register: a pixel register feeds the ink test and min/max
//   update, which loads the result register on the cell_end word.
//   When fit stalls, one result waits in the result register and pix keeps
//   taking words until a second cell_end needs that register.
//   Reset loads the register defaults, clears the ink extent and empties
//   both stages.
// ----------------------------------------------------------------------------
module glyph_cell_tight_fit
	import gctf_pkg::*;
#(
	parameter int MAX_CELL_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	gctf_pix_if.sink          pix,
	gctf_fit_if.source        fit
);

	localparam int TOP_W = (MAX_CELL_WIDTH < COL_LIMIT) ? MAX_CELL_WIDTH : COL_LIMIT;
	localparam logic [WIDTH_W-1:0] TOP_WIDTH = WIDTH_W'(TOP_W);

	cfg_t cfg;

	gctf_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pixel stage
	logic               valid_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic [COL_W-1:0]   column_s1;
	logic               end_s1;
	logic               nofit_s1;

	// cell extent
	logic [COL_W-1:0]   first_q;
	logic [COL_W-1:0]   last_q;
	logic               seen_q;

	// result register
	logic               out_valid_q;
	logic [COL_W-1:0]   left_q;
	logic [WIDTH_W-1:0] width_q;
	logic               found_q;

	logic               out_free;
	logic               advance;
	logic [WIDTH_W-1:0] eff_width;
	logic               in_cell;
	logic               ink;
	logic [RGB_W-1:0]   rgb;
	logic [COL_W-1:0]   first_nx;
	logic [COL_W-1:0]   last_nx;
	logic               seen_nx;

	assign out_free = !out_valid_q || fit.ready;
	assign advance  = valid_s1 && (!end_s1 || out_free);
	assign pix.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix.ready && pix.valid) begin
			pixel_s1  <= pix.pixel;
			column_s1 <= pix.column;
			end_s1    <= pix.cell_end;
			nofit_s1  <= pix.no_fit;
		end
	end

	always_comb begin
		if (cfg.cell_width == '0) begin
			eff_width = WIDTH_W'(1);
		end else if (cfg.cell_width > TOP_WIDTH) begin
			eff_width = TOP_WIDTH;
		end else begin
			eff_width = cfg.cell_width;
		end
	end

	assign rgb     = pixel_s1[RGB_W-1:0];
	assign in_cell = {1'b0, column_s1} < eff_width;

	always_comb begin
		if (cfg.use_alpha) begin
			ink = pixel_s1[31:24] != 8'd0;
		end else begin
			ink = (rgb != cfg.paper) && (rgb != cfg.paper2);
		end
	end

	always_comb begin
		first_nx = first_q;
		last_nx  = last_q;
		seen_nx  = seen_q;
		if (in_cell && ink) begin
			seen_nx = 1'b1;
			if (!seen_q) begin
				first_nx = column_s1;
				last_nx  = column_s1;
			end else begin
				if (column_s1 < first_q) first_nx = column_s1;
				if (column_s1 > last_q)  last_nx  = column_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q  <= '0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			if (end_s1) begin
				first_q <= '0;
				last_q  <= '0;
				seen_q  <= 1'b0;
			end else begin
				first_q <= first_nx;
				last_q  <= last_nx;
				seen_q  <= seen_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (fit.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			if (seen_nx && !nofit_s1) begin
				left_q  <= first_nx;
				width_q <= WIDTH_W'({1'b0, last_nx} - {1'b0, first_nx} + 7'd1);
				found_q <= 1'b1;
			end else begin
				left_q  <= '0;
				width_q <= eff_width;
				found_q <= 1'b0;
			end
		end
	end

	assign fit.valid       = out_valid_q;
	assign fit.left_offset = left_q;
	assign fit.fit_width   = width_q;
	assign fit.found       = found_q;

	// a waiting result never gets overwritten by the next cell
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !fit.ready) |=> out_valid_q && $stable(left_q) && $stable(width_q))
		else $error("result register overwritten while stalled");

	a_extent_order: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (first_q <= last_q))
		else $error("ink extent inverted");

	a_empty_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (left_q == '0))
		else $error("empty cell reports nonzero offset");

	a_width_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (width_q != '0) && (width_q <= TOP_WIDTH)
			&& ({1'b0, left_q} + width_q <= TOP_WIDTH))
		else $error("fit extends past the cell");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && end_s1))
		else $error("result without a cell end");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for glyph_cell_tight_fit: streams pixel words of glyph
// cells under random source and sink idling, tracks the ink extent of every
// cell alongside the block and compares each fit word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import gctf_pkg::*;

	localparam int          MAX_CELL       = 64;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          HOLD_CYCLES    = 150;
	localparam int          MAX_IDLE       = 14;
	localparam int          TAIL_CYCLES    = 10;
	localparam int          ERR_PRINT_MAX  = 40;
	localparam logic [1:0]  REG_UNUSED     = 2'd3;

	typedef struct packed {
		logic [COL_W-1:0]   left;
		logic [WIDTH_W-1:0] span;
		logic               found;
	} fit_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	gctf_pix_if pix_bus ();
	gctf_fit_if fit_bus ();

	glyph_cell_tight_fit #(
		.MAX_CELL_WIDTH(MAX_CELL)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix_bus),
		.fit     (fit_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register copies and ink extent as the block should hold them
	logic [RGB_W-1:0]   cfg_paper = PAPER_RESET;
	logic               cfg_alpha = 1'b1;
	logic [WIDTH_W-1:0] cfg_width = WIDTH_RESET;
	logic [COL_W-1:0]   ink_first = '0;
	logic [COL_W-1:0]   ink_last = '0;
	logic               ink_seen = 1'b0;

	fit_word_t fit_expect_q[$];
	int        err_cnt = 0;
	int        items_sent = 0;
	int        stall_cycles = 0;
	int        hold_req = 0;
	bit        src_idle = 1'b1;
	bit        sink_idle = 1'b1;

	function automatic logic [RGB_W-1:0] dim_paper(input logic [RGB_W-1:0] rgb);
		int               k;
		int               ch;
		logic             shrink;
		logic [RGB_W-1:0] res;
		shrink = rgb[23] | rgb[15] | rgb[7];
		for (k = 0; k < 3; k++) begin
			ch = int'(rgb[8*k +: 8]);
			ch = shrink ? (ch * 2) / 3 : (ch * 4) / 3;
			if (ch > 255)
				ch = 255;
			res[8*k +: 8] = 8'(ch);
		end
		return res;
	endfunction

	function automatic int cell_span();
		int w;
		w = int'(cfg_width);
		if (w < 1)
			w = 1;
		if (w > MAX_CELL)
			w = MAX_CELL;
		return w;
	endfunction

	// update the ink extent for one accepted pixel word, queue the fit word on cell end
	function automatic void track_ink(input logic [PIXEL_W-1:0] px, input logic [COL_W-1:0] col,
		input logic cend, input logic nofit);
		int        w;
		logic      ink;
		fit_word_t want;
		w = cell_span();
		if (int'(col) < w) begin
			if (cfg_alpha)
				ink = (px[31:24] != 8'h00);
			else
				ink = (px[23:0] != cfg_paper) && (px[23:0] != dim_paper(cfg_paper));
			if (ink) begin
				if (!ink_seen) begin
					ink_first = col;
					ink_last  = col;
					ink_seen  = 1'b1;
				end else begin
					if (col < ink_first)
						ink_first = col;
					if (col > ink_last)
						ink_last = col;
				end
			end
		end
		if (cend) begin
			if (ink_seen && !nofit) begin
				want.left  = ink_first;
				want.span  = {1'b0, ink_last} - {1'b0, ink_first} + 7'd1;
				want.found = 1'b1;
			end else begin
				want.left  = '0;
				want.span  = WIDTH_W'(w);
				want.found = 1'b0;
			end
			fit_expect_q.push_back(want);
			ink_first = '0;
			ink_last  = '0;
			ink_seen  = 1'b0;
		end
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic [COL_W-1:0] col,
		input logic cend, input logic nofit);
		int gap;
		gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
		if (gap != 0) begin
			pix_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_bus.valid    <= 1'b1;
		pix_bus.pixel    <= px;
		pix_bus.column   <= col;
		pix_bus.cell_end <= cend;
		pix_bus.no_fit   <= nofit;
		do
			@(posedge clk);
		while (!(pix_bus.valid && pix_bus.ready));
		track_ink(px, col, cend, nofit);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic pause_until_drained();
		pix_bus.valid <= 1'b0;
		while (fit_expect_q.size() != 0)
			@(posedge clk);
		// words without cell_end may still be in the pipe
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		pause_until_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_PAPER: cfg_paper = val[RGB_W-1:0];
			REG_ALPHA: cfg_alpha = val[0];
			REG_WIDTH: cfg_width = val[WIDTH_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic logic [PIXEL_W-1:0] make_pixel(input bit want_ink);
		logic [PIXEL_W-1:0] px;
		px = $urandom;
		if (cfg_alpha) begin
			px[31:24] = want_ink ? 8'($urandom_range(1, 255)) : 8'h00;
		end else if (!want_ink) begin
			px[23:0] = $urandom_range(0, 1) ? cfg_paper : dim_paper(cfg_paper);
		end
		return px;
	endfunction

	// mostly short cells in random column order, sometimes a full row scan
	task automatic send_random_cell();
		int         w;
		int         len;
		int         density;
		int         c;
		bit         scan;
		logic       last;
		logic [5:0] col;
		w       = cell_span();
		density = $urandom_range(0, 3);
		scan    = ($urandom_range(0, 9) == 0);
		len     = scan ? w : $urandom_range(1, 8);
		for (c = 0; c < len; c++) begin
			if (scan)
				col = 6'(c);
			else if ($urandom_range(0, 7) == 0)
				col = 6'($urandom_range(0, 63));
			else
				col = 6'($urandom_range(0, w - 1));
			last = (c == len - 1);
			send_pixel(make_pixel($urandom_range(0, 2) < density), col, last,
				last ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_alpha_defaults();
		send_pixel(32'h00123456, 6'd0, 1'b0, 1'b0);
		send_pixel(32'h01000000, 6'd3, 1'b0, 1'b0);
		send_pixel(32'hFF000000, 6'd5, 1'b0, 1'b1);   // no-fit away from cell end
		send_pixel(32'h00FFFFFF, 6'd7, 1'b1, 1'b0);
		send_pixel(32'hFFFFFFFF, 6'd63, 1'b0, 1'b0);  // outside the cell
		send_pixel(32'h80000000, 6'd6, 1'b0, 1'b0);
		send_pixel(32'h20000000, 6'd1, 1'b1, 1'b0);   // right to left
		send_pixel(32'h00000000, 6'd0, 1'b1, 1'b0);
		send_pixel(32'h7F000000, 6'd2, 1'b0, 1'b0);
		send_pixel(32'h01000000, 6'd4, 1'b1, 1'b1);
		send_pixel(32'hFFFFFFFF, 6'd8, 1'b1, 1'b0);
	endtask

	task automatic test_color_papers();
		write_reg(REG_ALPHA, 32'd0);
		write_reg(REG_PAPER, 32'h000000);
		send_pixel(32'hFF000000, 6'd0, 1'b0, 1'b0);
		send_pixel(32'h00000001, 6'd2, 1'b1, 1'b0);
		write_reg(REG_PAPER, 32'hFFFFFF);
		send_pixel(32'h00AAAAAA, 6'd0, 1'b0, 1'b0);
		send_pixel(32'h12FFFFFF, 6'd1, 1'b0, 1'b0);
		send_pixel(32'h00ABAAAA, 6'd7, 1'b1, 1'b0);
		write_reg(REG_PAPER, 32'h7F7F7F);
		send_pixel(32'h00A9A9A9, 6'd3, 1'b0, 1'b0);
		send_pixel(32'h007F7F7F, 6'd4, 1'b0, 1'b0);
		send_pixel(32'h00000000, 6'd5, 1'b1, 1'b0);
	endtask

	task automatic test_width_limits();
		write_reg(REG_ALPHA, 32'd1);
		write_reg(REG_WIDTH, 32'd0);
		send_pixel(32'hFF000000, 6'd1, 1'b0, 1'b0);
		send_pixel(32'hFF000000, 6'd0, 1'b1, 1'b0);
		write_reg(REG_WIDTH, 32'd127);
		send_pixel(32'hFF000000, 6'd63, 1'b0, 1'b0);
		send_pixel(32'h01000000, 6'd0, 1'b1, 1'b0);
		write_reg(REG_WIDTH, 32'd64);
		write_reg(REG_UNUSED, 32'hFFFFFFFF);
		send_pixel(32'h00000000, 6'd63, 1'b1, 1'b0);
		write_reg(REG_WIDTH, 32'd1);
		send_pixel(32'hFFFFFFFF, 6'd0, 1'b1, 1'b1);
	endtask

	task automatic test_random_cells();
		int                 phase;
		int                 start;
		logic [RGB_W-1:0]   paper;
		logic [WIDTH_W-1:0] width;
		for (phase = 0; phase < 7; phase++) begin
			case ($urandom_range(0, 4))
				0: paper = 24'h000000;
				1: paper = 24'hFFFFFF;
				2: paper = 24'h7F7F7F;
				3: paper = 24'h808080;
				default: paper = 24'($urandom);
			endcase
			case ($urandom_range(0, 6))
				0: width = 7'd0;
				1: width = 7'd1;
				2: width = 7'd64;
				3: width = 7'd127;
				default: width = 7'($urandom_range(2, 24));
			endcase
			// junk in the unused upper bits must not matter
			write_reg(REG_PAPER, {8'($urandom), paper});
			write_reg(REG_ALPHA, {31'($urandom), 1'($urandom_range(0, 1))});
			write_reg(REG_WIDTH, {25'($urandom), width});
			src_idle  = (phase % 3 != 0);
			sink_idle = (phase % 4 != 1);
			start     = items_sent;
			while (items_sent - start < 55)
				send_random_cell();
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_output_backpressure();
		int n;
		write_reg(REG_ALPHA, 32'd1);
		write_reg(REG_WIDTH, 32'd8);
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		hold_req  = HOLD_CYCLES;
		for (n = 0; n < 30; n++) begin
			send_pixel(make_pixel(n % 3 != 0), 6'($urandom_range(0, 7)), 1'b0, 1'b0);
			send_pixel(make_pixel(n % 4 != 0), 6'($urandom_range(0, 7)), 1'b1,
				1'($urandom_range(0, 5) == 0));
		end
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_drain_pause();
		int n;
		for (n = 0; n < 6; n++)
			send_random_cell();
		pause_until_drained();
		for (n = 0; n < 6; n++)
			send_random_cell();
	endtask

	// sink side: random hold-off per word, one long hold on request
	initial begin
		int gap;
		int n;
		fit_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req != 0) begin
				fit_bus.ready <= 1'b0;
				for (n = 0; n < hold_req; n++)
					@(negedge clk);
				hold_req = 0;
			end
			gap = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
			if (gap != 0) begin
				fit_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			fit_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(fit_bus.valid && fit_bus.ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : check_fit
		fit_word_t want;
		if (arst_n && fit_bus.valid && fit_bus.ready) begin
			if (fit_expect_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= ERR_PRINT_MAX)
					$display("%0t: unexpected fit word: expected none, got %0d/%0d/%0d",
						$time, fit_bus.left_offset, fit_bus.fit_width, fit_bus.found);
			end else begin
				want = fit_expect_q.pop_front();
				if (fit_bus.left_offset !== want.left) begin
					err_cnt++;
					if (err_cnt <= ERR_PRINT_MAX)
						$display("%0t: left_offset expected %0d, got %0d",
							$time, want.left, fit_bus.left_offset);
				end
				if (fit_bus.fit_width !== want.span) begin
					err_cnt++;
					if (err_cnt <= ERR_PRINT_MAX)
						$display("%0t: fit_width expected %0d, got %0d",
							$time, want.span, fit_bus.fit_width);
				end
				if (fit_bus.found !== want.found) begin
					err_cnt++;
					if (err_cnt <= ERR_PRINT_MAX)
						$display("%0t: found expected %0d, got %0d",
							$time, want.found, fit_bus.found);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_bus.valid && pix_bus.ready) || (fit_bus.valid && fit_bus.ready) ||
				(psel && penable))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d fit words outstanding",
					$time, stall_cycles, fit_expect_q.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		pix_bus.valid    = 1'b0;
		pix_bus.pixel    = '0;
		pix_bus.column   = '0;
		pix_bus.cell_end = 1'b0;
		pix_bus.no_fit   = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_alpha_defaults();
		test_color_papers();
		test_width_limits();
		test_random_cells();
		test_output_backpressure();
		test_drain_pause();

		pix_bus.valid <= 1'b0;
		while (fit_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
